>>> rtl/core/ttci_pkg.sv
package ttci_pkg;

  localparam logic [7:0] CH_INTRO   = 8'h5E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [7:0] CMD_CLEAR  = 8'h63;
  localparam logic [7:0] CMD_HOME   = 8'h68;
  localparam logic [7:0] CMD_BOL    = 8'h62;
  localparam logic [7:0] CMD_DOWN   = 8'h64;
  localparam logic [7:0] CMD_UP     = 8'h75;
  localparam logic [7:0] CMD_LEFT   = 8'h6C;
  localparam logic [7:0] CMD_RIGHT  = 8'h72;
  localparam logic [7:0] CMD_ERASE  = 8'h65;
  localparam logic [7:0] CMD_INSERT = 8'h69;
  localparam logic [7:0] CMD_OVER   = 8'h6F;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_PUT   = 3'd1;
  localparam logic [2:0] OP_INS   = 3'd2;
  localparam logic [2:0] OP_CLR   = 3'd3;
  localparam logic [2:0] OP_ERASE = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] cur_row;
    logic [3:0] cur_col;
    logic       ins;
  } ttci_op_t;

endpackage

>>> rtl/core/ttci_if.sv
interface ttci_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] byte_in;
  logic [3:0] read_row;
  logic [3:0] read_col;

  modport source (output valid, func, byte_in, read_row, read_col, input ready);
  modport sink (input valid, func, byte_in, read_row, read_col, output ready);
endinterface

interface ttci_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [3:0] cursor_row;
  logic [3:0] cursor_col;
  logic       insert_on;

  modport source (output valid, cell_char, cursor_row, cursor_col, insert_on, input ready);
  modport sink (input valid, cell_char, cursor_row, cursor_col, insert_on, output ready);
endinterface

>>> rtl/core/ttci_front.sv
module ttci_front #(
  parameter int SCREEN_DIM = 10
) (
  input  logic              clk,
  input  logic              rst,
  ttci_in_if.sink           req,
  input  logic              q_full,
  output logic              q_push,
  output ttci_pkg::ttci_op_t q_data
);
  import ttci_pkg::*;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_INTRO  = 2'd1;
  localparam logic [1:0] PH_ROW    = 2'd2;
  localparam logic [3:0] LAST      = 4'(SCREEN_DIM - 1);

  logic [1:0] phase, phase_next;
  logic [3:0] pending_row, pending_row_next;
  logic [3:0] row_pos, row_pos_next;
  logic [3:0] col_pos, col_pos_next;
  logic       insert_mode, insert_mode_next;

  logic       is_dig;
  logic [3:0] dpos;
  logic       show;
  logic [7:0] show_ch;
  logic [7:0] b;

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;
  assign b         = req.byte_in;
  assign is_dig    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dpos      = (b[3:0] > LAST) ? LAST : b[3:0];

  always_comb begin
    phase_next       = phase;
    pending_row_next = pending_row;
    row_pos_next     = row_pos;
    col_pos_next     = col_pos;
    insert_mode_next = insert_mode;
    show             = 1'b0;
    show_ch          = b;
    q_data           = '0;
    q_data.kind      = OP_NONE;
    q_data.row       = row_pos;
    q_data.col       = col_pos;

    if (req.func) begin
      q_data.row = req.read_row;
      q_data.col = req.read_col;
      if (req.read_row <= LAST && req.read_col <= LAST) begin
        q_data.kind = OP_READ;
      end
    end else begin
      unique case (phase)
        PH_INTRO: begin
          if (is_dig) begin
            pending_row_next = dpos;
            phase_next       = PH_ROW;
          end else begin
            phase_next = PH_NORMAL;
            unique case (b)
              CMD_CLEAR:  q_data.kind = OP_CLR;
              CMD_HOME: begin
                row_pos_next = '0;
                col_pos_next = '0;
              end
              CMD_BOL:    col_pos_next = '0;
              CMD_DOWN:   if (row_pos < LAST) row_pos_next = row_pos + 4'd1;
              CMD_UP:     if (row_pos != '0) row_pos_next = row_pos - 4'd1;
              CMD_LEFT:   if (col_pos != '0) col_pos_next = col_pos - 4'd1;
              CMD_RIGHT:  if (col_pos < LAST) col_pos_next = col_pos + 4'd1;
              CMD_ERASE:  q_data.kind = OP_ERASE;
              CMD_INSERT: insert_mode_next = 1'b1;
              CMD_OVER:   insert_mode_next = 1'b0;
              CH_INTRO: begin
                show    = 1'b1;
                show_ch = CH_INTRO;
              end
              default: ;
            endcase
          end
        end
        PH_ROW: begin
          phase_next = PH_NORMAL;
          if (is_dig) begin
            row_pos_next = pending_row;
            col_pos_next = dpos;
          end
        end
        default: begin
          phase_next = PH_NORMAL;
          if (b == CH_INTRO) begin
            phase_next = PH_INTRO;
          end else if (b != CH_NEWLINE) begin
            show = 1'b1;
          end
        end
      endcase

      if (show) begin
        q_data.kind = insert_mode ? OP_INS : OP_PUT;
        q_data.ch   = show_ch;
        if (col_pos < LAST) col_pos_next = col_pos + 4'd1;
      end
    end

    q_data.cur_row = row_pos_next;
    q_data.cur_col = col_pos_next;
    q_data.ins     = insert_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NORMAL;
      pending_row <= '0;
      row_pos     <= '0;
      col_pos     <= '0;
      insert_mode <= 1'b0;
    end else if (q_push) begin
      phase       <= phase_next;
      pending_row <= pending_row_next;
      row_pos     <= row_pos_next;
      col_pos     <= col_pos_next;
      insert_mode <= insert_mode_next;
    end
  end

endmodule

>>> rtl/core/ttci_queue.sv
module ttci_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ttci_pkg::ttci_op_t wdata,
  output logic               full,
  input  logic               pop,
  output ttci_pkg::ttci_op_t rdata,
  output logic               empty
);
  import ttci_pkg::*;

  ttci_op_t       slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");

endmodule

>>> rtl/core/ttci_back.sv
module ttci_back #(
  parameter int SCREEN_DIM = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  ttci_pkg::ttci_op_t q_data,
  output logic               q_pop,
  ttci_out_if.source         rsp
);
  import ttci_pkg::*;

  localparam int         CELLS = SCREEN_DIM * SCREEN_DIM;
  localparam int         AW    = $clog2(CELLS);
  localparam logic [3:0] LAST  = 4'(SCREEN_DIM - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state;
  ttci_op_t         cur;
  logic [7:0]       cell_q;
  logic [3:0]       k;
  logic [3:0]       wr_col;
  logic             rd_pend;

  logic [7:0]       mem [CELLS];
  logic [CELLS-1:0] vld;
  logic [7:0]       rdata;
  logic             rvalid;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [7:0]       wdata;
  logic             wbit;
  logic [AW-1:0]    raddr;
  logic             out_free;

  function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
    return AW'(32'(r) * SCREEN_DIM + 32'(c));
  endfunction

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    we    = 1'b0;
    waddr = cell_addr(cur.row, cur.col);
    wdata = cur.ch;
    wbit  = 1'b1;
    raddr = cell_addr(q_data.row, q_data.col);
    if (state == S_SHIFT) begin
      raddr = cell_addr(cur.row, 4'(k - 4'd1));
      if (rd_pend) begin
        we    = 1'b1;
        waddr = cell_addr(cur.row, wr_col);
        wdata = rdata;
        wbit  = rvalid;
      end
    end else if (state == S_PUT) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata  <= mem[raddr];
    rvalid <= vld[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (q_pop && q_data.kind == OP_CLR) begin
      vld <= '0;
    end else if (q_pop && q_data.kind == OP_ERASE) begin
      for (int r = 0; r < SCREEN_DIM; r++) begin
        for (int c = 0; c < SCREEN_DIM; c++) begin
          if (q_data.row == 4'(r) && 4'(c) >= q_data.col) vld[r*SCREEN_DIM+c] <= 1'b0;
        end
      end
    end else if (we) begin
      vld[waddr] <= wbit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !(state == S_EMIT && out_free)) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur     <= q_data;
            cell_q  <= '0;
            k       <= LAST;
            rd_pend <= 1'b0;
            priority case (q_data.kind)
              OP_PUT:  state <= S_PUT;
              OP_INS:  state <= (q_data.col >= LAST) ? S_PUT : S_SHIFT;
              OP_READ: state <= S_READ;
              default: state <= S_EMIT;
            endcase
          end
        end
        S_SHIFT: begin
          if (k > cur.col) begin
            rd_pend <= 1'b1;
            wr_col  <= k;
            k       <= k - 4'd1;
          end else begin
            rd_pend <= 1'b0;
            state   <= S_PUT;
          end
        end
        S_PUT: state <= S_EMIT;
        S_READ: begin
          cell_q <= rvalid ? rdata : CH_SPACE;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp.valid      <= 1'b1;
            rsp.cell_char  <= cell_q;
            rsp.cursor_row <= cur.cur_row;
            rsp.cursor_col <= cur.cur_col;
            rsp.insert_on  <= cur.ins;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (k >= cur.col)) else $error("shift pointer passed cursor");
  a_shift_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (cur.kind == OP_INS)) else $error("shift without insert op");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.cell_char) &&
    $stable(rsp.cursor_row) && $stable(rsp.cursor_col) && $stable(rsp.insert_on)))
    else $error("result changed while stalled");

endmodule

>>> rtl/core/text_terminal_control_interpreter_unit.sv
// Channel  Role   Payload
// req      sink   func, byte_in, read_row, read_col
// rsp      source cell_char, cursor_row, cursor_col, insert_on
//
// Parser and cursor run at one item per cycle, while the queue has room, into a 4-entry op queue.
// Back end takes one item at a time: control-only items go straight to emit, put and read pass
// through a write or read state, and an insert before the last column first shifts the row right.
// Sync reset clears parser, cursor and cell valid bits (screen reads as spaces).
// req stalls only when the queue is full; rsp is a holding register.
module text_terminal_control_interpreter_unit #(
  parameter int SCREEN_DIM = 10
) (
  input  logic        clk,
  input  logic        rst,
  ttci_in_if.sink     req,
  ttci_out_if.source  rsp
);
  import ttci_pkg::*;

  ttci_op_t push_data;
  ttci_op_t pop_data;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  ttci_front #(.SCREEN_DIM(SCREEN_DIM)) u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  ttci_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .pop   (pop),
    .rdata (pop_data),
    .empty (empty)
  );

  ttci_back #(.SCREEN_DIM(SCREEN_DIM)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (empty),
    .q_data  (pop_data),
    .q_pop   (pop),
    .rsp     (rsp)
  );

endmodule
